/* rtl/mipmap_box_downsampler_unit_macros.svh */
// Assertion macros shared by the downsampler RTL.
`ifndef MIPMAP_BOX_DOWNSAMPLER_UNIT_MACROS_SVH
`define MIPMAP_BOX_DOWNSAMPLER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MBD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mbd_pkg.sv */
// Package with widths, register codes and the sRGB conversion tables.
package mbd_pkg;

  localparam int LIN_FRAC  = 16;
  localparam int LIN_W     = LIN_FRAC + 1;
  localparam int HSUM_W    = LIN_W + 1;
  localparam int TOT_W     = LIN_W + 2;
  localparam int MAX_W     = 4096;
  localparam int MAX_H     = 4096;
  localparam int DIM_W     = 13;
  localparam int COORD_W   = 12;
  localparam int ROW_DEPTH = MAX_W / 2;
  localparam int ROW_AW    = $clog2(ROW_DEPTH);
  localparam int NUM_CH    = 4;
  localparam int NUM_COL   = 3;
  localparam int ENC_STEPS = 8;
  localparam int MEM_W     = NUM_CH * HSUM_W;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_PLAIN  = 2'd2
  } cfg_reg_e;

  typedef logic [LIN_W-1:0] lin_t;
  typedef lin_t lut_t [256];

  // Side data that travels alongside the encoder pipeline.
  typedef struct packed {
    logic                 plain;
    logic                 last;
    logic [NUM_CH-1:0][7:0] mean;
  } side_t;

  // Restoring division, used only while building the tables.
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] q31_mul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 31;
  endfunction

  // Largest Q31 value whose fifth power does not exceed v.
  function automatic logic [63:0] fifth_root(input logic [63:0] v);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] sq;
    logic [63:0] p;
    lo = '0;
    hi = 64'd1 << 31;
    for (int i = 0; i < 40; i++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        sq  = q31_mul(mid, mid);
        p   = q31_mul(q31_mul(sq, sq), mid);
        if (p <= v) lo = mid;
        else        hi = mid - 64'd1;
      end
    end
    return lo;
  endfunction

  // Linear light of the sRGB fraction n/d in 1.LIN_FRAC fixed point.
  function automatic logic [63:0] to_linear(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] y;
    logic [63:0] v;
    if (n * 64'd100000 <= d * 64'd4045) begin
      return udiv64(((n * 64'd100) << LIN_FRAC) + d * 64'd646, d * 64'd1292);
    end
    x  = udiv64((64'd1000 * n + 64'd55 * d) << 31, 64'd1055 * d);
    x2 = q31_mul(x, x);
    y  = fifth_root(x2);
    v  = q31_mul(x2, y);
    return (v + (64'd1 << (30 - LIN_FRAC))) >> (31 - LIN_FRAC);
  endfunction

  function automatic lut_t build_decode();
    lut_t t;
    logic [63:0] v;
    for (int c = 0; c < 256; c++) begin
      v    = to_linear(64'(c), 64'd255);
      t[c] = v[LIN_W-1:0];
    end
    return t;
  endfunction

  function automatic lut_t build_threshold();
    lut_t t;
    logic [63:0] v;
    t[0] = '0;
    for (int c = 1; c < 256; c++) begin
      v    = to_linear(64'(2 * c - 1), 64'd510);
      t[c] = v[LIN_W-1:0];
    end
    return t;
  endfunction

  localparam lut_t DECODE_LUT = build_decode();
  localparam lut_t THRESH_LUT = build_threshold();

endpackage

/* rtl/mbd_srgb_encoder.sv */
// Pipelined binary search that turns scaled linear sums into sRGB codes.
module mbd_srgb_encoder
  import mbd_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [TOT_W-1:0] sum_i  [NUM_COL],
  output logic [7:0]       code_o [NUM_COL]
);

  logic [TOT_W-1:0] sum_q  [ENC_STEPS][NUM_COL];
  logic [7:0]       code_q [ENC_STEPS][NUM_COL];

  // One code bit is resolved per stage, most significant first.
  for (genvar s = 0; s < ENC_STEPS; s++) begin : g_step
    for (genvar k = 0; k < NUM_COL; k++) begin : g_col
      logic [TOT_W-1:0] prev_sum;
      logic [7:0]       prev_code;
      logic [7:0]       trial;
      lin_t             thr;
      if (s == 0) begin : g_first
        assign prev_sum  = sum_i[k];
        assign prev_code = '0;
      end else begin : g_next
        assign prev_sum  = sum_q[s-1][k];
        assign prev_code = code_q[s-1][k];
      end
      assign trial = prev_code | (8'h80 >> s);
      assign thr   = THRESH_LUT[trial];

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          sum_q[s][k]  <= prev_sum;
          code_q[s][k] <= ({thr, 2'b00} <= prev_sum) ? trial : prev_code;
        end
      end
    end
  end

  for (genvar k = 0; k < NUM_COL; k++) begin : g_out
    assign code_o[k] = code_q[ENC_STEPS-1][k];
  end

endmodule

/* rtl/mipmap_box_downsampler_unit.sv */
// Top level of the 2x2 box mipmap downsampler with optional sRGB averaging.
//
// Source pixels enter on the input channel in raster order, one beat per
// pixel, and the next mip level leaves on the output channel. Every odd
// column of an odd row completes a 2x2 block and yields one output beat;
// other pixels are absorbed; a dimension of one is not halved. last_pixel_o
// marks the final pixel of a level. A pixel is taken in every cycle unless
// the output is stalled; a result passes the first stage, where the row
// memory is read, the eight sRGB code search steps and the output register.
// Horizontal pair sums of even rows are held in a 2048-entry row memory
// with a registered read, written in the even row and read in the following
// row. The width, height and plain mode registers are written through the
// config port; the user must write them only while the block is idle, which
// the block does not enforce. Writing any of them restarts the frame at
// pixel zero. Reset sets a 1x1 image in sRGB mode and empties the pipeline.
// When the receiver stalls, the whole pipeline holds and in_stall_o is
// raised in the same cycle, so no result is lost or repeated.
`include "mipmap_box_downsampler_unit_macros.svh"

module mipmap_box_downsampler_unit
  import mbd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [DIM_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       red_in_i,
  input  logic [7:0]       green_in_i,
  input  logic [7:0]       blue_in_i,
  input  logic [7:0]       alpha_in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       red_out_o,
  output logic [7:0]       green_out_o,
  output logic [7:0]       blue_out_o,
  output logic [7:0]       alpha_out_o,
  output logic             last_pixel_o
);

  // Configuration registers.
  logic [DIM_W-1:0]   width_q, height_q;
  logic               plain_q;
  logic               cfg_hit;
  logic [DIM_W-1:0]   w_eff, h_eff;
  logic               w_one, h_one;

  assign cfg_hit = cfg_we_i && (cfg_index_i == REG_WIDTH || cfg_index_i == REG_HEIGHT ||
                                cfg_index_i == REG_PLAIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
      plain_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        REG_PLAIN:  plain_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Clamp the geometry to the supported range.
  always_comb begin
    w_eff = width_q;
    if (width_q == '0) w_eff = DIM_W'(1);
    else if (width_q > DIM_W'(MAX_W)) w_eff = DIM_W'(MAX_W);
    h_eff = height_q;
    if (height_q == '0) h_eff = DIM_W'(1);
    else if (height_q > DIM_W'(MAX_H)) h_eff = DIM_W'(MAX_H);
  end
  assign w_one = (w_eff == DIM_W'(1));
  assign h_one = (h_eff == DIM_W'(1));

  // Global pipeline advance: everything holds while a result is stalled.
  logic adv, acc;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign acc        = in_valid_i && adv;

  // Position counters.
  logic [COORD_W-1:0] col_q, row_q;
  logic               col_wrap, row_wrap;

  assign col_wrap = ({1'b0, col_q} + DIM_W'(1)) >= w_eff;
  assign row_wrap = ({1'b0, row_q} + DIM_W'(1)) >= h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_hit) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      if (col_wrap) begin
        col_q <= '0;
        row_q <= row_wrap ? '0 : row_q + COORD_W'(1);
      end else begin
        col_q <= col_q + COORD_W'(1);
      end
    end
  end

  // Decode the incoming pixel and form the horizontal pair sum.
  logic [7:0]        pix   [NUM_CH];
  logic [LIN_W-1:0]  val   [NUM_CH];
  logic [HSUM_W-1:0] hsum  [NUM_CH];
  logic [LIN_W-1:0]  pair_q [NUM_CH];

  assign pix[0] = red_in_i;
  assign pix[1] = green_in_i;
  assign pix[2] = blue_in_i;
  assign pix[3] = alpha_in_i;

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      if (plain_q || k == NUM_CH - 1) val[k] = LIN_W'(pix[k]);
      else                            val[k] = DECODE_LUT[pix[k]];
      hsum[k] = w_one ? HSUM_W'(val[k]) : HSUM_W'(pair_q[k]) + HSUM_W'(val[k]);
    end
  end

  // Classify the pixel within its block.
  logic              drop, even_col, even_row, fwd, mem_we, mem_re;
  logic [ROW_AW-1:0] idx;
  logic [DIM_W-1:0]  out_w, out_h, out_x, out_y;
  logic              last_pix;

  assign drop = (!w_one && ({1'b0, col_q} >= {w_eff[DIM_W-1:1], 1'b0})) ||
                (!h_one && ({1'b0, row_q} >= {h_eff[DIM_W-1:1], 1'b0}));
  assign even_col = !w_one && !col_q[0];
  assign even_row = !h_one && !row_q[0];
  assign idx      = w_one ? '0 : col_q[ROW_AW:1];
  assign mem_we   = acc && !cfg_hit && !drop && !even_col && even_row;
  assign mem_re   = acc && !cfg_hit && !drop && !even_col && !h_one && row_q[0];
  assign fwd      = acc && !cfg_hit && !drop && !even_col && !even_row;

  assign out_w    = w_one ? DIM_W'(1) : {1'b0, w_eff[DIM_W-1:1]};
  assign out_h    = h_one ? DIM_W'(1) : {1'b0, h_eff[DIM_W-1:1]};
  assign out_x    = DIM_W'(idx);
  assign out_y    = h_one ? '0 : DIM_W'(row_q[COORD_W-1:1]);
  assign last_pix = (out_x + DIM_W'(1) == out_w) && (out_y + DIM_W'(1) == out_h);

  // Even column keeps its decoded value for the odd column.
  always_ff @(posedge clk_i) begin
    if (acc && !drop && even_col) begin
      for (int k = 0; k < NUM_CH; k++) pair_q[k] <= val[k];
    end
  end

  // Row memory of even-row pair sums.
  logic [MEM_W-1:0] row_mem [ROW_DEPTH];
  logic [MEM_W-1:0] mem_wdata, mem_rd_q;

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) mem_wdata[k*HSUM_W +: HSUM_W] = hsum[k];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) row_mem[idx] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) mem_rd_q <= row_mem[idx];
  end

  // First stage: horizontal sum and block flags, waiting on the memory read.
  logic              s1_v_q, s1_use_mem_q, s1_hz_q, s1_last_q, s1_plain_q;
  logic [HSUM_W-1:0] s1_hsum_q [NUM_CH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= fwd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && fwd) begin
      s1_use_mem_q <= !h_one;
      s1_hz_q      <= !w_one;
      s1_last_q    <= last_pix;
      s1_plain_q   <= plain_q;
      for (int k = 0; k < NUM_CH; k++) s1_hsum_q[k] <= hsum[k];
    end
  end

  // Block total, plain means and scaled sums for the encoder.
  logic [TOT_W-1:0] total  [NUM_CH];
  logic [TOT_W-1:0] scaled [NUM_COL];
  logic [1:0]       sl;
  side_t            s1_side;

  assign sl = {1'b0, s1_hz_q} + {1'b0, s1_use_mem_q};

  always_comb begin
    s1_side.plain = s1_plain_q;
    s1_side.last  = s1_last_q;
    for (int k = 0; k < NUM_CH; k++) begin
      total[k] = TOT_W'(s1_hsum_q[k]) +
                 (s1_use_mem_q ? TOT_W'(mem_rd_q[k*HSUM_W +: HSUM_W]) : '0);
      s1_side.mean[k] = 8'(total[k] >> sl);
    end
    for (int k = 0; k < NUM_COL; k++) scaled[k] = total[k] << (2'd2 - sl);
  end

  // sRGB re-encoding pipeline with its side data.
  logic [7:0] code [NUM_COL];
  side_t      side_q [ENC_STEPS];
  logic [ENC_STEPS-1:0] pv_q;

  mbd_srgb_encoder u_enc (
    .clk_i  (clk_i),
    .en_i   (adv),
    .sum_i  (scaled),
    .code_o (code)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else if (adv) begin
      pv_q <= {pv_q[ENC_STEPS-2:0], s1_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= s1_side;
      for (int s = 1; s < ENC_STEPS; s++) side_q[s] <= side_q[s-1];
    end
  end

  // Output register; alpha is always the plain mean.
  logic       out_valid_q;
  logic [7:0] res [NUM_CH];
  logic [7:0] res_q [NUM_CH];
  logic       last_q;

  always_comb begin
    for (int k = 0; k < NUM_COL; k++) begin
      if (side_q[ENC_STEPS-1].plain) res[k] = side_q[ENC_STEPS-1].mean[k];
      else                           res[k] = code[k];
    end
    res[NUM_CH-1] = side_q[ENC_STEPS-1].mean[NUM_CH-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= pv_q[ENC_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && pv_q[ENC_STEPS-1]) begin
      for (int k = 0; k < NUM_CH; k++) res_q[k] <= res[k];
      last_q <= side_q[ENC_STEPS-1].last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = res_q[0];
  assign green_out_o  = res_q[1];
  assign blue_out_o   = res_q[2];
  assign alpha_out_o  = res_q[3];
  assign last_pixel_o = last_q;

  // Checks on the pipeline control.
  `MBD_ASSERT_IMP(a_stall, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "stray stall")
  `MBD_ASSERT_NXT(a_restart, clk_i, rst_ni, cfg_hit, col_q == '0 && row_q == '0, "no restart")
  `MBD_ASSERT_NXT(a_drain, clk_i, rst_ni, pv_q[ENC_STEPS-1] && adv, out_valid_o, "result lost")

endmodule
